/* rtl/rufp_pkg.sv */
// Package for the RFID UART frame parser.
// Holds the parse phase type, error codes, register indexes and reset values.
// Depends on nothing; used by rtl/rfid_uart_frame_parser.sv.
package rufp_pkg;

    // Parse phase of the frame tracker.
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_TYPE     = 3'd1,
        PH_COMMAND  = 3'd2,
        PH_LENGTH   = 3'd3,
        PH_PAYLOAD  = 3'd4,
        PH_CHECKSUM = 3'd5,
        PH_FOOTER   = 3'd6
    } phase_t;

    // Error codes reported with each result.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TYPE     = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;
    localparam logic [1:0] ERR_FOOTER   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HEADER   = 3'd0;
    localparam logic [2:0] CFG_FOOTER   = 3'd1;
    localparam logic [2:0] CFG_CMD_TYPE = 3'd2;
    localparam logic [2:0] CFG_RSP_TYPE = 3'd3;
    localparam logic [2:0] CFG_NTF_TYPE = 3'd4;

    // Configuration reset values.
    localparam logic [7:0] RST_HEADER   = 8'hBB;
    localparam logic [7:0] RST_FOOTER   = 8'h7E;
    localparam logic [7:0] RST_CMD_TYPE = 8'h00;
    localparam logic [7:0] RST_RSP_TYPE = 8'h01;
    localparam logic [7:0] RST_NTF_TYPE = 8'h02;

    // Number of big-endian length bytes.
    localparam logic [15:0] LENGTH_BYTES = 16'd2;

endpackage

/* rtl/rfid_uart_frame_parser.sv */
// RFID UART frame parser: an input transfer lands in the input register and its
// result moves on into the result register once that register is free.
// Throughput is one byte per cycle while the result channel accepts results;
// the per-byte state update is a single 16-bit increment and compare between
// those two registers.
// Reset (aresetn low, synchronous) empties both registers, returns the parser
// to waiting for a header and loads the default configuration codes.
// Depends on rtl/rufp_pkg.sv.
module rfid_uart_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_done,
    output logic [1:0]  m_error_code,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_index,
    output logic [7:0]  m_frame_type,
    output logic [7:0]  m_frame_command,
    output logic [15:0] m_frame_length,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Configuration registers.
    logic [7:0] header_code_reg;
    logic [7:0] footer_code_reg;
    logic [7:0] cmd_type_reg;
    logic [7:0] rsp_type_reg;
    logic [7:0] ntf_type_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parser state.
    rufp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [7:0]  held_cmd_reg, held_cmd_next;
    logic [15:0] held_len_reg, held_len_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  sum_reg, sum_next;

    // Result register.
    logic        out_valid_reg;
    logic        out_done_reg, out_done_next;
    logic [1:0]  out_err_reg, out_err_next;
    logic        out_pvalid_reg, out_pvalid_next;
    logic [7:0]  out_pbyte_reg, out_pbyte_next;
    logic [15:0] out_pindex_reg, out_pindex_next;

    logic        advance;
    logic        type_ok;
    logic [15:0] count_inc;
    logic [15:0] len_shift;

    // The input register moves into the result register when that is free.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_code_reg <= rufp_pkg::RST_HEADER;
            footer_code_reg <= rufp_pkg::RST_FOOTER;
            cmd_type_reg    <= rufp_pkg::RST_CMD_TYPE;
            rsp_type_reg    <= rufp_pkg::RST_RSP_TYPE;
            ntf_type_reg    <= rufp_pkg::RST_NTF_TYPE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rufp_pkg::CFG_HEADER:   header_code_reg <= cfg_data;
                rufp_pkg::CFG_FOOTER:   footer_code_reg <= cfg_data;
                rufp_pkg::CFG_CMD_TYPE: cmd_type_reg    <= cfg_data;
                rufp_pkg::CFG_RSP_TYPE: rsp_type_reg    <= cfg_data;
                rufp_pkg::CFG_NTF_TYPE: ntf_type_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Per-byte frame tracking and result formation.
    assign type_ok   = (in_byte_reg == cmd_type_reg) || (in_byte_reg == rsp_type_reg) ||
                       (in_byte_reg == ntf_type_reg);
    assign count_inc = byte_count_reg + 16'd1;
    assign len_shift = {held_len_reg[7:0], in_byte_reg};

    always_comb begin
        phase_next      = phase_reg;
        held_type_next  = held_type_reg;
        held_cmd_next   = held_cmd_reg;
        held_len_next   = held_len_reg;
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        out_done_next   = 1'b0;
        out_err_next    = rufp_pkg::ERR_NONE;
        out_pvalid_next = 1'b0;
        out_pbyte_next  = 8'd0;
        out_pindex_next = 16'd0;

        unique case (phase_reg)
            rufp_pkg::PH_TYPE: begin
                if (type_ok) begin
                    held_type_next = in_byte_reg;
                    sum_next       = in_byte_reg;
                    phase_next     = rufp_pkg::PH_COMMAND;
                end else begin
                    out_err_next = rufp_pkg::ERR_TYPE;
                    phase_next   = rufp_pkg::PH_HEADER;
                end
            end
            rufp_pkg::PH_COMMAND: begin
                held_cmd_next   = in_byte_reg;
                sum_next        = sum_reg + in_byte_reg;
                held_len_next   = 16'd0;
                byte_count_next = 16'd0;
                phase_next      = rufp_pkg::PH_LENGTH;
            end
            rufp_pkg::PH_LENGTH: begin
                held_len_next   = len_shift;
                sum_next        = sum_reg + in_byte_reg;
                byte_count_next = count_inc;
                if (count_inc >= rufp_pkg::LENGTH_BYTES) begin
                    byte_count_next = 16'd0;
                    phase_next = (len_shift != 16'd0) ? rufp_pkg::PH_PAYLOAD
                                                      : rufp_pkg::PH_CHECKSUM;
                end
            end
            rufp_pkg::PH_PAYLOAD: begin
                out_pvalid_next = 1'b1;
                out_pbyte_next  = in_byte_reg;
                out_pindex_next = byte_count_reg;
                sum_next        = sum_reg + in_byte_reg;
                byte_count_next = count_inc;
                if (count_inc >= held_len_reg) begin
                    phase_next = rufp_pkg::PH_CHECKSUM;
                end
            end
            rufp_pkg::PH_CHECKSUM: begin
                if (sum_reg == in_byte_reg) begin
                    phase_next = rufp_pkg::PH_FOOTER;
                end else begin
                    out_err_next = rufp_pkg::ERR_CHECKSUM;
                    phase_next   = rufp_pkg::PH_HEADER;
                end
            end
            rufp_pkg::PH_FOOTER: begin
                if (in_byte_reg == footer_code_reg) begin
                    out_done_next = 1'b1;
                end else begin
                    out_err_next = rufp_pkg::ERR_FOOTER;
                end
                phase_next = rufp_pkg::PH_HEADER;
            end
            default: begin
                // Waiting for a header; anything else is dropped silently.
                phase_next = (in_byte_reg == header_code_reg) ? rufp_pkg::PH_TYPE
                                                              : rufp_pkg::PH_HEADER;
            end
        endcase
    end

    // Parser state update on each byte that moves to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= rufp_pkg::PH_HEADER;
            held_type_reg  <= 8'd0;
            held_cmd_reg   <= 8'd0;
            held_len_reg   <= 16'd0;
            byte_count_reg <= 16'd0;
            sum_reg        <= 8'd0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            held_type_reg  <= held_type_next;
            held_cmd_reg   <= held_cmd_next;
            held_len_reg   <= held_len_next;
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_done_reg   <= out_done_next;
            out_err_reg    <= out_err_next;
            out_pvalid_reg <= out_pvalid_next;
            out_pbyte_reg  <= out_pbyte_next;
            out_pindex_reg <= out_pindex_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_done    = out_done_reg;
    assign m_error_code    = out_err_reg;
    assign m_payload_valid = out_pvalid_reg;
    assign m_payload_byte  = out_pbyte_reg;
    assign m_payload_index = out_pindex_reg;
    assign m_frame_type    = held_type_reg;
    assign m_frame_command = held_cmd_reg;
    assign m_frame_length  = held_len_reg;

    // A payload result never carries an error or a frame completion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_pvalid_reg) |->
            (out_err_reg == rufp_pkg::ERR_NONE) && !out_done_reg)
        else $error("payload result carries an error or completion");

    // A completed frame reports no error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_done_reg) |-> (out_err_reg == rufp_pkg::ERR_NONE))
        else $error("frame completion reported with an error");

    // Non-payload results have zero payload byte and index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_pvalid_reg) |->
            (out_pbyte_reg == 8'd0) && (out_pindex_reg == 16'd0))
        else $error("payload fields not cleared outside the payload");

    // In the payload phase the length is nonzero and the count stays below it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == rufp_pkg::PH_PAYLOAD) |->
            (held_len_reg != 16'd0) && (byte_count_reg < held_len_reg))
        else $error("payload count out of range");

    // The length phase counts at most two bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == rufp_pkg::PH_LENGTH) |-> (byte_count_reg < rufp_pkg::LENGTH_BYTES))
        else $error("length byte count out of range");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the RFID UART frame parser (rfid_uart_frame_parser).
// An in-order frame tracker predicts one result per accepted byte under
// randomized flow control. Depends on rtl/rufp_pkg.sv and rtl/rfid_uart_frame_parser.sv.
module testbench;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BYTES   = 85;
    localparam int TAIL_PAYLOAD  = 30;
    localparam logic [2:0] CFG_INDEX_MAX = 3'd7;

    // One expected result of the parser.
    typedef struct packed {
        logic        done;
        logic [1:0]  err;
        logic        pvalid;
        logic [7:0]  pbyte;
        logic [15:0] pindex;
        logic [7:0]  ftype;
        logic [7:0]  fcmd;
        logic [15:0] flen;
    } parse_result_t;

    // Ways a generated frame can be broken.
    typedef enum int {FAULT_NONE, FAULT_TYPE, FAULT_SUM, FAULT_FOOTER} frame_fault_t;

    // Receiver ready patterns.
    typedef enum int {SINK_STREAM, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE} sink_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_frame_done;
    logic [1:0]  m_error_code;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_payload_index;
    logic [7:0]  m_frame_type;
    logic [7:0]  m_frame_command;
    logic [15:0] m_frame_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = rufp_pkg::CFG_HEADER;
    logic [7:0]  cfg_data = 8'h00;

    // Predicted register contents.
    logic [7:0]  reg_header = rufp_pkg::RST_HEADER;
    logic [7:0]  reg_footer = rufp_pkg::RST_FOOTER;
    logic [7:0]  reg_cmd_type = rufp_pkg::RST_CMD_TYPE;
    logic [7:0]  reg_rsp_type = rufp_pkg::RST_RSP_TYPE;
    logic [7:0]  reg_ntf_type = rufp_pkg::RST_NTF_TYPE;

    // Predicted frame tracker state.
    rufp_pkg::phase_t trk_phase = rufp_pkg::PH_HEADER;
    logic [7:0]  trk_type = 8'h00;
    logic [7:0]  trk_cmd = 8'h00;
    logic [15:0] trk_length = 16'h0000;
    logic [15:0] trk_count = 16'h0000;
    logic [7:0]  trk_sum = 8'h00;

    parse_result_t pending_parse_results[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    sink_mode_t  sink_mode = SINK_STREAM;
    int          sink_run_left = 0;

    rfid_uart_frame_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_done    (m_frame_done),
        .m_error_code    (m_error_code),
        .m_payload_valid (m_payload_valid),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_type    (m_frame_type),
        .m_frame_command (m_frame_command),
        .m_frame_length  (m_frame_length),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Runaway guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rfid_uart_frame_parser: mismatch");
            $finish;
        end
    end

    // Receiver back-pressure: runs of one pattern, switching at random.
    always @(negedge aclk) begin
        if (sink_run_left == 0) begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            sink_run_left <= $urandom_range(4, 40);
        end else begin
            sink_run_left <= sink_run_left - 1;
        end
        case (sink_mode)
            SINK_STREAM: m_ready <= 1'b1;
            SINK_LIGHT:  m_ready <= ($urandom_range(0, 3) != 0);
            SINK_HEAVY:  m_ready <= ($urandom_range(0, 3) == 0);
            default:     m_ready <= ~m_ready;
        endcase
    end

    function automatic bit type_ok(input logic [7:0] value);
        return value == reg_cmd_type || value == reg_rsp_type || value == reg_ntf_type;
    endfunction

    // Advance the predicted tracker by one byte and queue the result it yields.
    task automatic track_frame_byte(input logic [7:0] value);
        parse_result_t res;
        res = '0;
        case (trk_phase)
            rufp_pkg::PH_TYPE: begin
                if (type_ok(value)) begin
                    trk_type = value;
                    trk_sum = value;
                    trk_phase = rufp_pkg::PH_COMMAND;
                end else begin
                    res.err = rufp_pkg::ERR_TYPE;
                    trk_phase = rufp_pkg::PH_HEADER;
                end
            end
            rufp_pkg::PH_COMMAND: begin
                trk_cmd = value;
                trk_sum = trk_sum + value;
                trk_length = 16'h0000;
                trk_count = 16'h0000;
                trk_phase = rufp_pkg::PH_LENGTH;
            end
            rufp_pkg::PH_LENGTH: begin
                trk_length = {trk_length[7:0], value};
                trk_sum = trk_sum + value;
                trk_count = trk_count + 16'd1;
                if (trk_count >= rufp_pkg::LENGTH_BYTES) begin
                    trk_count = 16'h0000;
                    trk_phase = (trk_length != 16'h0000) ? rufp_pkg::PH_PAYLOAD
                                                         : rufp_pkg::PH_CHECKSUM;
                end
            end
            rufp_pkg::PH_PAYLOAD: begin
                res.pvalid = 1'b1;
                res.pbyte = value;
                res.pindex = trk_count;
                trk_sum = trk_sum + value;
                trk_count = trk_count + 16'd1;
                if (trk_count >= trk_length) trk_phase = rufp_pkg::PH_CHECKSUM;
            end
            rufp_pkg::PH_CHECKSUM: begin
                if (trk_sum == value) begin
                    trk_phase = rufp_pkg::PH_FOOTER;
                end else begin
                    res.err = rufp_pkg::ERR_CHECKSUM;
                    trk_phase = rufp_pkg::PH_HEADER;
                end
            end
            rufp_pkg::PH_FOOTER: begin
                if (value == reg_footer) res.done = 1'b1;
                else res.err = rufp_pkg::ERR_FOOTER;
                trk_phase = rufp_pkg::PH_HEADER;
            end
            default: begin
                trk_phase = (value == reg_header) ? rufp_pkg::PH_TYPE : rufp_pkg::PH_HEADER;
            end
        endcase
        res.ftype = trk_type;
        res.fcmd = trk_cmd;
        res.flen = trk_length;
        pending_parse_results.push_back(res);
    endtask

    // Send one byte, opening a random gap at the start of each burst.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!s_ready);
        track_frame_byte(value);
        bytes_sent++;
    endtask

    // Send a frame. A nonzero sum_delta corrupts the checksum; the frame then
    // stops there, as it does after a rejected type byte.
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] cmd,
                              input logic [15:0] len, input logic [7:0] sum_delta,
                              input logic [7:0] footer, input bit header_fill);
        logic [7:0] sum;
        logic [7:0] pb;
        int i;
        sum = ftype + cmd + len[15:8] + len[7:0];
        send_byte(reg_header);
        send_byte(ftype);
        if (!type_ok(ftype)) return;
        send_byte(cmd);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (i = 0; i < len; i++) begin
            pb = header_fill ? reg_header : 8'($urandom);
            sum = sum + pb;
            send_byte(pb);
        end
        send_byte(sum + sum_delta);
        if (sum_delta != 8'h00) return;
        send_byte(footer);
    endtask

    // Stop sending and wait until the parser has returned every result.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_parse_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; valid stays high so that writes can follow back to back.
    task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rufp_pkg::CFG_HEADER:   reg_header = value;
            rufp_pkg::CFG_FOOTER:   reg_footer = value;
            rufp_pkg::CFG_CMD_TYPE: reg_cmd_type = value;
            rufp_pkg::CFG_RSP_TYPE: reg_rsp_type = value;
            rufp_pkg::CFG_NTF_TYPE: reg_ntf_type = value;
            default: ;
        endcase
    endtask

    // Load all five codes plus one write to an unused index, then release.
    task automatic load_config(input logic [7:0] hdr, input logic [7:0] ftr,
                               input logic [7:0] cmd_t, input logic [7:0] rsp_t,
                               input logic [7:0] ntf_t);
        drain_results();
        write_register(rufp_pkg::CFG_HEADER, hdr);
        write_register(rufp_pkg::CFG_FOOTER, ftr);
        write_register(rufp_pkg::CFG_CMD_TYPE, cmd_t);
        write_register(rufp_pkg::CFG_RSP_TYPE, rsp_t);
        write_register(rufp_pkg::CFG_NTF_TYPE, ntf_t);
        write_register(3'($urandom_range(CFG_INDEX_MAX, rufp_pkg::CFG_NTF_TYPE + 1)),
                       8'($urandom));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly clean frames with random content, some broken, some line noise.
    task automatic send_random_frame();
        frame_fault_t fault;
        logic [7:0] ftype;
        logic [7:0] ftr;
        logic [15:0] len;
        int pick;
        int i;
        pick = $urandom_range(0, 15);
        fault = (pick < 12) ? FAULT_NONE : frame_fault_t'(pick - 12);
        if ($urandom_range(0, 3) == 0) begin
            for (i = $urandom_range(1, 3); i > 0; i--) send_byte(8'($urandom));
        end
        case ($urandom_range(0, 2))
            0:       ftype = reg_cmd_type;
            1:       ftype = reg_rsp_type;
            default: ftype = reg_ntf_type;
        endcase
        if (fault == FAULT_TYPE) begin
            do ftype = 8'($urandom); while (type_ok(ftype));
        end
        ftr = reg_footer;
        if (fault == FAULT_FOOTER) begin
            do ftr = 8'($urandom); while (ftr == reg_footer);
        end
        len = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
        send_frame(ftype, 8'($urandom), len,
                   (fault == FAULT_SUM) ? 8'($urandom_range(1, 255)) : 8'h00,
                   ftr, 1'b0);
    endtask

    // Default codes: idle noise, empty frame, rejected type equal to the
    // header, header value as payload, bad checksum, footer equal to header.
    task automatic test_defaults_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(rufp_pkg::RST_CMD_TYPE, 8'h00, 16'd0, 8'h00, rufp_pkg::RST_FOOTER, 1'b0);
        send_frame(rufp_pkg::RST_HEADER, 8'h00, 16'd0, 8'h00, rufp_pkg::RST_FOOTER, 1'b0);
        send_frame(rufp_pkg::RST_NTF_TYPE, 8'hFF, 16'd1, 8'h00, rufp_pkg::RST_FOOTER, 1'b1);
        send_frame(rufp_pkg::RST_RSP_TYPE, 8'h5A, 16'd0, 8'h01, rufp_pkg::RST_FOOTER, 1'b0);
        send_frame(rufp_pkg::RST_RSP_TYPE, 8'hA5, 16'd0, 8'h00, rufp_pkg::RST_HEADER, 1'b0);
    endtask

    // Extreme register values, including all three type codes equal.
    task automatic test_register_extremes();
        load_config(8'h00, 8'hFF, 8'hFF, 8'h80, 8'h7F);
        send_frame(8'hFF, 8'h00, 16'd3, 8'h00, 8'hFF, 1'b0);
        send_frame(8'h80, 8'hFF, 16'd2, 8'h00, 8'hFF, 1'b1);
        send_frame(8'h7F, 8'h33, 16'd0, 8'h00, 8'h00, 1'b0);
        load_config(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(8'h00, 8'hFF, 16'd4, 8'h00, 8'h00, 1'b0);
        send_frame(8'h01, 8'h00, 16'd0, 8'h00, 8'h00, 1'b0);
        send_frame(8'h00, 8'h80, 16'd1, 8'h80, 8'h00, 1'b0);
    endtask

    // Random traffic over several random settings, one of them the defaults.
    task automatic test_random_traffic();
        int ph;
        int start;
        logic [7:0] t0;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            t0 = 8'($urandom);
            if (ph == 0) begin
                load_config(rufp_pkg::RST_HEADER, rufp_pkg::RST_FOOTER,
                            rufp_pkg::RST_CMD_TYPE, rufp_pkg::RST_RSP_TYPE,
                            rufp_pkg::RST_NTF_TYPE);
            end else if (ph == 1) begin
                load_config(8'($urandom), 8'($urandom), t0, t0, 8'($urandom));
            end else begin
                load_config(8'($urandom), 8'($urandom), t0, 8'($urandom), 8'($urandom));
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) send_random_frame();
        end
    endtask

    // One frame whose length needs the upper length byte.
    task automatic test_long_payload();
        send_frame(reg_rsp_type, 8'($urandom), 16'($urandom_range(256, 300)), 8'h00,
                   reg_footer, 1'b0);
    endtask

    // Largest length: the payload cannot finish within the run, so only its
    // start is exercised, last of all.
    task automatic test_max_length_tail();
        int i;
        send_byte(reg_header);
        send_byte(reg_ntf_type);
        send_byte(8'($urandom));
        send_byte(8'hFF);
        send_byte(8'hFF);
        for (i = 0; i < TAIL_PAYLOAD; i++) send_byte(8'($urandom));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare every result transfer with the oldest prediction.
    always @(posedge aclk) begin : result_check
        parse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_parse_results.size() == 0) begin
                $error("result transfer with no byte outstanding");
                mismatch_count++;
            end else begin
                want = pending_parse_results.pop_front();
                check_field("frame_done", want.done, m_frame_done);
                check_field("error_code", want.err, m_error_code);
                check_field("payload_valid", want.pvalid, m_payload_valid);
                check_field("payload_byte", want.pbyte, m_payload_byte);
                check_field("payload_index", want.pindex, m_payload_index);
                check_field("frame_type", want.ftype, m_frame_type);
                check_field("frame_command", want.fcmd, m_frame_command);
                check_field("frame_length", want.flen, m_frame_length);
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_defaults_directed();
        test_register_extremes();
        test_random_traffic();
        test_long_payload();
        test_max_length_tail();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_parse_results.size() == 0) begin
            $display("rfid_uart_frame_parser: match");
        end else begin
            $display("rfid_uart_frame_parser: mismatch");
        end
        $finish;
    end

endmodule

/* rfid_uart_frame_parser.f */
rtl/rufp_pkg.sv
rtl/rfid_uart_frame_parser.sv
test/testbench.sv
